// File: rtl/nfsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfsa_pkg: shared types and constants of the next-fit slot allocator
// Holds the bitmap geometry, the command and result beats, status codes and
// the controller state encoding.
// ----------------------------------------------------------------------------
package nfsa_pkg;

    // Bitmap geometry; capacity and word width are powers of two
    localparam int CAPACITY = 256;
    localparam int WORD_W   = 32;
    localparam int WORDS    = CAPACITY / WORD_W;
    localparam int WADDR_W  = $clog2(WORDS);
    localparam int OFF_W    = $clog2(WORD_W);
    localparam int KCNT_W   = $clog2(WORDS + 1);

    // Field widths
    localparam int SLOT_W   = 8;
    localparam int CFG_W    = 9;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(256);

    // Command codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FREE
    } t_state;

    typedef struct packed {
        logic              action;
        logic [SLOT_W-1:0] slot_index;
    } t_cmd;

    typedef struct packed {
        logic [SLOT_W-1:0] granted_index;
        t_status           status;
    } t_result;

endpackage

// File: rtl/nfsa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfsa_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered and appears in the cycle after the read.
// ----------------------------------------------------------------------------
module nfsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/next_fit_slot_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_fit_slot_allocator: next-fit bitmap slot allocator
// Occupancy bitmap in a word-wide RAM, a rover, and a read-modify-write
// controller that answers every command with exactly one result beat.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its one result beat
// shows on o_result for a single cycle with o_done high, and the receiver
// must take it then, since the block never holds a result back. A free out of
// range is answered with a range status beat without touching the bitmap, a
// free reads and rewrites one word, and an allocate sweeps the 32-bit bitmap
// words from the rover's word to the word holding the granted slot, up to WORDS
// words past the rover's word; a full heap costs the whole sweep. The bitmap
// RAM's read port delivers one word per cycle to the scan. Reset takes no
// clearing pass: a valid flag per bitmap word makes an unwritten word read as
// free. The user must write slots_in_use through i_cfg_we / i_cfg_wdata only
// while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module next_fit_slot_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  nfsa_pkg::t_cmd                  i_cmd,
    output logic                            o_done,
    output nfsa_pkg::t_result               o_result,
    input  logic                            i_cfg_we,
    input  logic [nfsa_pkg::CFG_W-1:0]      i_cfg_wdata
);

    // Registers
    nfsa_pkg::t_state                    r_state, n_state;
    logic [nfsa_pkg::CFG_W-1:0]          r_slots;
    logic [nfsa_pkg::CFG_W-1:0]          r_rover, n_rover;
    logic [nfsa_pkg::WORDS-1:0]          r_row_vld, n_row_vld;
    logic                                r_rd_vld;
    logic [nfsa_pkg::WADDR_W-1:0]        r_sw, n_sw;
    logic [nfsa_pkg::OFF_W-1:0]          r_off, n_off;
    logic [nfsa_pkg::KCNT_W-1:0]         r_ik, n_ik;
    logic                                r_ev_vld, n_ev_vld;
    logic [nfsa_pkg::KCNT_W-1:0]         r_ev_k, n_ev_k;
    logic [nfsa_pkg::WADDR_W-1:0]        r_ev_addr, n_ev_addr;
    logic [nfsa_pkg::SLOT_W-1:0]         r_fslot, n_fslot;
    logic                                r_done, n_done;
    nfsa_pkg::t_result                   r_res, n_res;

    // RAM ports
    logic                                ram_we, ram_re;
    logic [nfsa_pkg::WADDR_W-1:0]        ram_waddr, ram_raddr;
    logic [nfsa_pkg::WORD_W-1:0]         ram_wdata, ram_rdata;

    // Scan datapath
    logic [nfsa_pkg::CFG_W-1:0]          mng;
    logic [nfsa_pkg::CFG_W-1:0]          start_pos;
    logic [nfsa_pkg::WORD_W-1:0]         word_q;
    logic [nfsa_pkg::WORD_W-1:0]         free_vec;
    logic                                hit;
    logic [nfsa_pkg::OFF_W-1:0]          hit_bit;
    logic [nfsa_pkg::SLOT_W-1:0]         hit_slot;
    logic                                accept;

    nfsa_ram #(
        .WIDTH (nfsa_pkg::WORD_W),
        .DEPTH (nfsa_pkg::WORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign accept = start && !busy;
    assign busy   = (r_state != nfsa_pkg::S_IDLE);

    // Saturate the managed count to the built capacity
    assign mng = (r_slots > nfsa_pkg::CFG_W'(nfsa_pkg::CAPACITY))
               ? nfsa_pkg::CFG_W'(nfsa_pkg::CAPACITY) : r_slots;

    // Scan from the rover, or from zero when the rover is past the range
    assign start_pos = (r_rover < mng) ? r_rover : '0;

    // Words never written read as all free
    assign word_q = ram_rdata & {nfsa_pkg::WORD_W{r_rd_vld}};

    // Mask the word to the managed range and the current sweep phase
    always_comb begin
        free_vec = ~word_q;
        for (int b = 0; b < nfsa_pkg::WORD_W; b++) begin
            if (nfsa_pkg::CFG_W'({r_ev_addr, nfsa_pkg::OFF_W'(b)}) >= mng) begin
                free_vec[b] = 1'b0;
            end
            if (r_ev_k == '0 && nfsa_pkg::OFF_W'(b) < r_off) begin
                free_vec[b] = 1'b0;
            end
            if (r_ev_k == nfsa_pkg::KCNT_W'(nfsa_pkg::WORDS)
                && nfsa_pkg::OFF_W'(b) >= r_off) begin
                free_vec[b] = 1'b0;
            end
        end
    end

    // Pick the lowest free bit
    always_comb begin
        hit     = 1'b0;
        hit_bit = '0;
        for (int b = nfsa_pkg::WORD_W - 1; b >= 0; b--) begin
            if (free_vec[b]) begin
                hit     = 1'b1;
                hit_bit = nfsa_pkg::OFF_W'(b);
            end
        end
    end

    assign hit_slot = {r_ev_addr, hit_bit};

    // Hold the configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= nfsa_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_slots <= i_cfg_wdata;
        end
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= nfsa_pkg::S_IDLE;
            r_rover   <= '0;
            r_row_vld <= '0;
            r_ev_vld  <= 1'b0;
            r_done    <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rover   <= n_rover;
            r_row_vld <= n_row_vld;
            r_ev_vld  <= n_ev_vld;
            r_done    <= n_done;
            if (ram_re) begin
                r_rd_vld <= r_row_vld[ram_raddr];
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_sw      <= n_sw;
        r_off     <= n_off;
        r_ik      <= n_ik;
        r_ev_k    <= n_ev_k;
        r_ev_addr <= n_ev_addr;
        r_fslot   <= n_fslot;
        r_res     <= n_res;
    end

    // Next state, memory access and result
    always_comb begin
        n_state   = r_state;
        n_rover   = r_rover;
        n_row_vld = r_row_vld;
        n_sw      = r_sw;
        n_off     = r_off;
        n_ik      = r_ik;
        n_ev_vld  = 1'b0;
        n_ev_k    = r_ev_k;
        n_ev_addr = r_ev_addr;
        n_fslot   = r_fslot;
        n_done    = 1'b0;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_waddr = r_ev_addr;
        ram_wdata = word_q;
        ram_re    = 1'b0;
        ram_raddr = '0;

        case (r_state)
            nfsa_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_cmd.action == nfsa_pkg::ACT_ALLOC) begin
                        n_sw    = start_pos[nfsa_pkg::SLOT_W-1:nfsa_pkg::OFF_W];
                        n_off   = start_pos[nfsa_pkg::OFF_W-1:0];
                        n_ik    = '0;
                        n_state = nfsa_pkg::S_SCAN;
                    end else if (nfsa_pkg::CFG_W'(i_cmd.slot_index) < mng) begin
                        // Fetch the word holding the slot to release
                        ram_re    = 1'b1;
                        ram_raddr = i_cmd.slot_index[nfsa_pkg::SLOT_W-1:nfsa_pkg::OFF_W];
                        n_fslot   = i_cmd.slot_index;
                        n_state   = nfsa_pkg::S_FREE;
                    end else begin
                        // Drop an out-of-range free with a status beat
                        n_done              = 1'b1;
                        n_res.granted_index = '0;
                        n_res.status        = nfsa_pkg::ST_RANGE;
                    end
                end
            end

            nfsa_pkg::S_SCAN: begin
                // Issue the next word read of the sweep
                if (r_ik <= nfsa_pkg::KCNT_W'(nfsa_pkg::WORDS)) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_sw + r_ik[nfsa_pkg::WADDR_W-1:0];
                    n_ev_vld  = 1'b1;
                    n_ev_k    = r_ik;
                    n_ev_addr = ram_raddr;
                    n_ik      = r_ik + 1'b1;
                end
                // Evaluate the word read in the previous cycle
                if (r_ev_vld) begin
                    if (hit) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_ev_addr;
                        ram_wdata = word_q | (nfsa_pkg::WORD_W'(1) << hit_bit);
                        n_row_vld[r_ev_addr] = 1'b1;
                        n_rover   = nfsa_pkg::CFG_W'(hit_slot) + 1'b1;
                        n_done    = 1'b1;
                        n_res.granted_index = hit_slot;
                        n_res.status        = nfsa_pkg::ST_OK;
                        n_ev_vld  = 1'b0;
                        n_state   = nfsa_pkg::S_IDLE;
                    end else if (r_ev_k == nfsa_pkg::KCNT_W'(nfsa_pkg::WORDS)) begin
                        n_done    = 1'b1;
                        n_res.granted_index = '0;
                        n_res.status        = nfsa_pkg::ST_FULL;
                        n_ev_vld  = 1'b0;
                        n_state   = nfsa_pkg::S_IDLE;
                    end
                end
            end

            nfsa_pkg::S_FREE: begin
                // Clear the slot bit and pull the rover back to the slot if it lies below
                ram_we    = 1'b1;
                ram_waddr = r_fslot[nfsa_pkg::SLOT_W-1:nfsa_pkg::OFF_W];
                ram_wdata = word_q
                          & ~(nfsa_pkg::WORD_W'(1) << r_fslot[nfsa_pkg::OFF_W-1:0]);
                n_row_vld[ram_waddr] = 1'b1;
                if (nfsa_pkg::CFG_W'(r_fslot) < r_rover) begin
                    n_rover = nfsa_pkg::CFG_W'(r_fslot);
                end
                n_done              = 1'b1;
                n_res.granted_index = '0;
                n_res.status        = nfsa_pkg::ST_OK;
                n_state             = nfsa_pkg::S_IDLE;
            end

            default: begin
                n_state = nfsa_pkg::S_IDLE;
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_res;

    // Every result beat follows an accepted command or a busy cycle
    a_done_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(start && !busy) || $past(r_state != nfsa_pkg::S_IDLE)))
        else $error("result beat without a command");

    // An accepted command either goes busy or answers at once
    a_accept_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted command dropped");

    // The bitmap is only written while a command is being served
    a_we_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state != nfsa_pkg::S_IDLE))
        else $error("bitmap written while idle");

    // The sweep never evaluates past its closing partial word
    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ev_vld |-> (r_ev_k <= nfsa_pkg::KCNT_W'(nfsa_pkg::WORDS)))
        else $error("scan ran past the bitmap");

endmodule
